@@ hdl/dapt_pkg.sv @@
`timescale 1ns / 1ps

package dapt_pkg;

   // Table geometry
   localparam int FD_COUNT = 1024;
   localparam int FD_IDX_W = (FD_COUNT > 1) ? $clog2(FD_COUNT) : 1;

   // Event codes
   localparam logic [2:0] CMD_INHERIT    = 3'd0;
   localparam logic [2:0] CMD_OPEN_ANN   = 3'd1;
   localparam logic [2:0] CMD_OPEN_DONE  = 3'd2;
   localparam logic [2:0] CMD_CLOSE_DONE = 3'd3;
   localparam logic [2:0] CMD_READ       = 3'd4;
   localparam logic [2:0] CMD_WRITE      = 3'd5;

   // Access classes
   localparam logic [1:0] CLS_NONE   = 2'd0;
   localparam logic [1:0] CLS_ANY    = 2'd1;
   localparam logic [1:0] CLS_WONLY  = 2'd2;
   localparam logic [1:0] CLS_RTHENW = 2'd3;

   // Verdicts
   localparam logic [1:0] VERD_CONT = 2'd0;
   localparam logic [1:0] VERD_TERM = 2'd1;
   localparam logic [1:0] VERD_FAKE = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_UNEXP = 2'd2;

   // One table entry
   typedef struct packed {
      logic [1:0] cls;
      logic       rd_ok;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{cls: CLS_NONE, rd_ok: 1'b1};

endpackage

@@ hdl/descriptor_access_policy_table.sv @@
`timescale 1ns / 1ps

// Descriptor access policy table. Each request (inherit, open announce, open
// done, close done, read, write) gives exactly one response with a verdict
// and a status. The descriptor's entry is first read from a single
// synchronous table memory into a register, then modified, written back and
// loaded into the response register once no earlier response is waiting; the
// next request is taken once that write-back is done, even while the response
// waits to be taken. After reset a clearing pass writes each of the FD_COUNT
// (1024) entries once, during which no request is accepted.
module descriptor_access_policy_table
   import dapt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [15:0] req_fd,
   input  logic               req_call_failed,
   input  logic               req_is_log_file,
   input  logic               req_create_flag,
   input  logic               req_target_exists,
   input  logic               req_regular_or_dir,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_verdict,
   output logic [1:0]         rsp_status
);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;

   localparam logic [FD_IDX_W-1:0] FD_LAST = FD_IDX_W'(FD_COUNT - 1);

   logic [1:0]          state_ff, state_in;
   logic [FD_IDX_W-1:0] clr_idx_ff, clr_idx_in;

   entry_type           policy_mem [FD_COUNT];
   entry_type           rd_data_ff;

   logic [2:0]          cmd_ff;
   logic                fd_neg_ff;
   logic                in_range_ff;
   logic [FD_IDX_W-1:0] idx_ff;
   logic                failed_ff, logf_ff, creat_ff, exists_ff, regdir_ff;

   logic [1:0]          pend_ff, pend_in;
   logic                expf_ff, expf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_verdict_ff, rsp_status_ff;

   logic                accept, advance, req_in_range;
   logic [FD_IDX_W-1:0] req_idx;
   logic                mem_we;
   logic [FD_IDX_W-1:0] mem_wa;
   entry_type           mem_wd, lk_wd;
   logic                lk_we;
   logic [1:0]          verdict_in, status_in;

   // Range check and index of the incoming descriptor
   assign req_in_range = !req_fd[15] && ({1'b0, req_fd} < 17'(FD_COUNT));
   assign req_idx      = req_in_range ? req_fd[FD_IDX_W-1:0] : '0;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign advance   = (state_ff == S_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   // Apply the policy to the entry read back
   always_comb begin
      verdict_in = VERD_CONT;
      status_in  = STAT_OK;
      lk_we      = 1'b0;
      lk_wd      = rd_data_ff;
      pend_in    = pend_ff;
      expf_in    = expf_ff;
      case (cmd_ff)
         CMD_INHERIT: begin
            if (!in_range_ff) begin
               status_in = STAT_RANGE;
            end else begin
               lk_we     = 1'b1;
               lk_wd.cls = logf_ff ? CLS_ANY : CLS_WONLY;
            end
         end
         CMD_OPEN_ANN: begin
            pend_in = CLS_NONE;
            expf_in = 1'b0;
            if (logf_ff) begin
               pend_in = CLS_ANY;
            end else if (creat_ff) begin
               verdict_in = VERD_TERM;
            end else if (!exists_ff) begin
               expf_in = 1'b1;
            end else begin
               pend_in = regdir_ff ? CLS_RTHENW : CLS_WONLY;
            end
         end
         CMD_OPEN_DONE: begin
            if (!fd_neg_ff) begin
               if (expf_ff) begin
                  status_in = STAT_UNEXP;
               end else if (!in_range_ff) begin
                  status_in = STAT_RANGE;
               end else begin
                  lk_we     = 1'b1;
                  lk_wd.cls = pend_ff;
               end
            end
         end
         CMD_CLOSE_DONE: begin
            if (!failed_ff) begin
               if (!in_range_ff) begin
                  status_in = STAT_RANGE;
               end else begin
                  lk_we = 1'b1;
                  lk_wd = ENTRY_RESET;
               end
            end
         end
         CMD_READ: begin
            if (!in_range_ff) begin
               status_in  = STAT_RANGE;
               verdict_in = VERD_TERM;
            end else if (rd_data_ff.cls == CLS_ANY) begin
               verdict_in = VERD_CONT;
            end else if (rd_data_ff.cls == CLS_RTHENW) begin
               verdict_in = rd_data_ff.rd_ok ? VERD_CONT : VERD_TERM;
            end else begin
               verdict_in = VERD_TERM;
            end
         end
         CMD_WRITE: begin
            if (!in_range_ff) begin
               status_in  = STAT_RANGE;
               verdict_in = VERD_TERM;
            end else begin
               case (rd_data_ff.cls)
                  CLS_ANY:   verdict_in = VERD_CONT;
                  CLS_WONLY: verdict_in = VERD_FAKE;
                  CLS_RTHENW: begin
                     lk_we       = 1'b1;
                     lk_wd.rd_ok = 1'b0;
                     verdict_in  = VERD_FAKE;
                  end
                  default:   verdict_in = VERD_TERM;
               endcase
            end
         end
         default: begin
            verdict_in = VERD_CONT;
         end
      endcase
   end

   // Select the memory write: clearing pass or write-back
   always_comb begin
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_idx_ff;
         mem_wd = ENTRY_RESET;
      end else begin
         mem_we = advance && lk_we;
         mem_wa = idx_ff;
         mem_wd = lk_wd;
      end
   end

   // Sequence clearing, lookup and write-back
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == FD_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (advance) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Hold the response until it is taken
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         policy_mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         rd_data_ff <= policy_mem[req_idx];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         pend_ff      <= CLS_NONE;
         expf_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pend_ff <= pend_in;
            expf_ff <= expf_in;
         end
      end
   end

   // Capture the request and the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_cmd;
         fd_neg_ff   <= req_fd[15];
         in_range_ff <= req_in_range;
         idx_ff      <= req_idx;
         failed_ff   <= req_call_failed;
         logf_ff     <= req_is_log_file;
         creat_ff    <= req_create_flag;
         exists_ff   <= req_target_exists;
         regdir_ff   <= req_regular_or_dir;
      end
      if (advance) begin
         rsp_verdict_ff <= verdict_in;
         rsp_status_ff  <= status_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_status  = rsp_status_ff;

`ifndef SYNTH
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("accepted request not looked up");

   a_range_no_write: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_range_ff) |-> !mem_we)
      else $error("table written for out-of-range descriptor");

   a_unexp_only_open_done: assert property (@(posedge clock) disable iff (reset)
      (advance && status_in == STAT_UNEXP) |-> (cmd_ff == CMD_OPEN_DONE && !mem_we))
      else $error("unexpected open status on wrong event");

   a_rsp_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("response lost after write-back");
`endif

endmodule

@@ tb/sv/descriptor_access_policy_table_checker.sv @@
`timescale 1ns / 1ps

module descriptor_access_policy_table_checker
   import dapt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [15:0] req_fd,
   input  logic               req_call_failed,
   input  logic               req_is_log_file,
   input  logic               req_create_flag,
   input  logic               req_target_exists,
   input  logic               req_regular_or_dir,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_verdict,
   input  logic [1:0]         rsp_status,
   output int                 owed_count,
   output int                 checked_count,
   output int                 mismatch_count
);

   typedef struct packed {
      logic [1:0] verdict;
      logic [1:0] status;
   } policy_answer_t;

   // Shadow copy of the descriptor table and the staged open
   logic [1:0]     cls_of_fd [FD_COUNT];
   logic           may_read_fd [FD_COUNT];
   logic [1:0]     staged_cls;
   logic           open_should_fail;

   policy_answer_t owed_answers [$];
   int             answers_checked;
   int             answers_bad;

   initial begin
      owed_count     = 0;
      checked_count  = 0;
      mismatch_count = 0;
   end

   // Work out the answer to one request and update the shadow table
   function automatic policy_answer_t apply_descriptor_event(
      input logic [2:0]         cmd,
      input logic signed [15:0] fd,
      input logic               call_failed,
      input logic               is_log_file,
      input logic               create_flag,
      input logic               target_exists,
      input logic               regular_or_dir
   );
      policy_answer_t ans;
      logic           in_range;
      int             idx;
      in_range    = (fd >= 0) && (fd < FD_COUNT);
      idx         = in_range ? int'(fd) : 0;
      ans.verdict = VERD_CONT;
      ans.status  = STAT_OK;
      case (cmd)
         CMD_INHERIT: begin
            if (!in_range)
               ans.status = STAT_RANGE;
            else
               cls_of_fd[idx] = is_log_file ? CLS_ANY : CLS_WONLY;
         end
         CMD_OPEN_ANN: begin
            staged_cls       = CLS_NONE;
            open_should_fail = 1'b0;
            if (is_log_file)
               staged_cls = CLS_ANY;
            else if (create_flag)
               ans.verdict = VERD_TERM;
            else if (!target_exists)
               open_should_fail = 1'b1;
            else
               staged_cls = regular_or_dir ? CLS_RTHENW : CLS_WONLY;
         end
         CMD_OPEN_DONE: begin
            // a failed open leaves everything alone
            if (fd >= 0) begin
               if (open_should_fail)
                  ans.status = STAT_UNEXP;
               else if (!in_range)
                  ans.status = STAT_RANGE;
               else
                  cls_of_fd[idx] = staged_cls;
            end
         end
         CMD_CLOSE_DONE: begin
            if (!call_failed) begin
               if (!in_range) begin
                  ans.status = STAT_RANGE;
               end else begin
                  cls_of_fd[idx]   = CLS_NONE;
                  may_read_fd[idx] = 1'b1;
               end
            end
         end
         CMD_READ: begin
            if (!in_range) begin
               ans.status  = STAT_RANGE;
               ans.verdict = VERD_TERM;
            end else if (cls_of_fd[idx] == CLS_ANY) begin
               ans.verdict = VERD_CONT;
            end else if (cls_of_fd[idx] == CLS_RTHENW) begin
               ans.verdict = may_read_fd[idx] ? VERD_CONT : VERD_TERM;
            end else begin
               ans.verdict = VERD_TERM;
            end
         end
         CMD_WRITE: begin
            if (!in_range) begin
               ans.status  = STAT_RANGE;
               ans.verdict = VERD_TERM;
            end else if (cls_of_fd[idx] == CLS_ANY) begin
               ans.verdict = VERD_CONT;
            end else if (cls_of_fd[idx] == CLS_WONLY) begin
               ans.verdict = VERD_FAKE;
            end else if (cls_of_fd[idx] == CLS_RTHENW) begin
               // once written, the descriptor may not be read again
               may_read_fd[idx] = 1'b0;
               ans.verdict      = VERD_FAKE;
            end else begin
               ans.verdict = VERD_TERM;
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // Retire responses before taking new requests: a response never belongs to
   // the request accepted on the same edge
   always @(posedge clock) begin
      policy_answer_t want;
      policy_answer_t got;
      int             i;
      if (reset) begin
         for (i = 0; i < FD_COUNT; i++) begin
            cls_of_fd[i]   = CLS_NONE;
            may_read_fd[i] = 1'b1;
         end
         staged_cls       = CLS_NONE;
         open_should_fail = 1'b0;
         owed_answers.delete();
         answers_checked  = 0;
         answers_bad      = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.verdict = rsp_verdict;
            got.status  = rsp_status;
            if (owed_answers.size() == 0) begin
               answers_bad++;
               if (answers_bad <= 10)
                  $display("[%0t] response with nothing outstanding: verdict %0d status %0d",
                           $realtime, got.verdict, got.status);
            end else begin
               want = owed_answers.pop_front();
               if ((got.verdict !== want.verdict) || (got.status !== want.status)) begin
                  answers_bad++;
                  if (answers_bad <= 10)
                     $display("[%0t] response %0d: verdict %0d want %0d, status %0d want %0d",
                              $realtime, answers_checked, got.verdict, want.verdict,
                              got.status, want.status);
               end
            end
            answers_checked++;
         end
         if (req_valid && req_ready) begin
            want = apply_descriptor_event(req_cmd, req_fd, req_call_failed,
                                          req_is_log_file, req_create_flag,
                                          req_target_exists, req_regular_or_dir);
            owed_answers.push_back(want);
         end
      end
      owed_count     <= owed_answers.size();
      checked_count  <= answers_checked;
      mismatch_count <= answers_bad;
   end

endmodule

@@ tb/sv/descriptor_access_policy_table_test.sv @@
`timescale 1ns / 1ps

module descriptor_access_policy_table_test;
   import dapt_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int          RANDOM_ITEMS  = 1200;
   localparam int          SETTLE_CYCLES = 24;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic [2:0]         req_cmd            = CMD_READ;
   logic signed [15:0] req_fd             = '0;
   logic               req_call_failed    = 1'b0;
   logic               req_is_log_file    = 1'b0;
   logic               req_create_flag    = 1'b0;
   logic               req_target_exists  = 1'b0;
   logic               req_regular_or_dir = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready          = 1'b0;
   logic [1:0]         rsp_verdict;
   logic [1:0]         rsp_status;

   int                 owed_count;
   int                 checked_count;
   int                 mismatch_count;

   int unsigned        cycle_count = 0;
   int                 burst_left  = 0;
   int                 cmd_seen [8];
   int                 sent_total  = 0;

   descriptor_access_policy_table DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_fd             (req_fd),
      .req_call_failed    (req_call_failed),
      .req_is_log_file    (req_is_log_file),
      .req_create_flag    (req_create_flag),
      .req_target_exists  (req_target_exists),
      .req_regular_or_dir (req_regular_or_dir),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_status         (rsp_status)
   );

   descriptor_access_policy_table_checker policy_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_fd             (req_fd),
      .req_call_failed    (req_call_failed),
      .req_is_log_file    (req_is_log_file),
      .req_create_flag    (req_create_flag),
      .req_target_exists  (req_target_exists),
      .req_regular_or_dir (req_regular_or_dir),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_status         (rsp_status),
      .owed_count         (owed_count),
      .checked_count      (checked_count),
      .mismatch_count     (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // Response back-pressure: switch between stall styles every so often,
   // including stretches that never stall
   always @(posedge clock) begin
      int stall_style;
      if (cycle_count % 160 == 0)
         stall_style = $urandom_range(0, 3);
      case (stall_style)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((cycle_count % 5) < 2);
      endcase
   end

   // Offer one request and hold it until accepted; idle between bursts
   task automatic send_request(input logic [2:0]         cmd,
                               input logic signed [15:0] fd,
                               input logic               call_failed,
                               input logic               is_log_file,
                               input logic               create_flag,
                               input logic               target_exists,
                               input logic               regular_or_dir);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 32);
      end
      req_cmd            <= cmd;
      req_fd             <= fd;
      req_call_failed    <= call_failed;
      req_is_log_file    <= is_log_file;
      req_create_flag    <= create_flag;
      req_target_exists  <= target_exists;
      req_regular_or_dir <= regular_or_dir;
      req_valid          <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      burst_left--;
      cmd_seen[cmd]++;
      sent_total++;
   endtask

   // Hold off until every outstanding response has been taken
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0)
         @(posedge clock);
      burst_left = 0;
   endtask

   // Mostly a handful of live descriptors, some near the top of the table,
   // some out of range and some anywhere in 16 bits
   function automatic logic signed [15:0] pick_fd();
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         v = $urandom_range(0, 15);
      else if (pick < 80)
         v = $urandom_range(FD_COUNT - 8, FD_COUNT - 1);
      else if (pick < 85)
         v = $urandom_range(FD_COUNT, 32767);
      else if (pick < 90)
         v = -int'($urandom_range(1, 32768));
      else
         v = $urandom_range(0, 65535);
      return v[15:0];
   endfunction

   function automatic logic coin(input int percent);
      return ($urandom_range(0, 99) < percent);
   endfunction

   // One open announce / open done pair on a descriptor, some accesses, and
   // usually a close
   task automatic run_open_session();
      logic signed [15:0] fd;
      logic signed [15:0] done_fd;
      int                 accesses;
      int                 k;
      fd      = pick_fd();
      done_fd = coin(10) ? 16'(-int'($urandom_range(1, 32768))) : fd;
      send_request(CMD_OPEN_ANN, pick_fd(), coin(50), coin(20), coin(15), coin(80), coin(50));
      send_request(CMD_OPEN_DONE, done_fd, coin(50), coin(50), coin(50), coin(50), coin(50));
      accesses = $urandom_range(0, 6);
      for (k = 0; k < accesses; k++)
         send_request(coin(50) ? CMD_READ : CMD_WRITE, fd, coin(50), coin(50), coin(50),
                      coin(50), coin(50));
      if (coin(60))
         send_request(CMD_CLOSE_DONE, fd, coin(15), coin(50), coin(50), coin(50), coin(50));
   endtask

   initial begin
      int random_sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: every class, every event, the edges of the descriptor range
      send_request(CMD_WRITE,      16'sd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_INHERIT,    16'sd0,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_request(CMD_READ,       16'sd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_WRITE,      16'sd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_INHERIT,    16'sd1,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_READ,       16'sd1,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_WRITE,      16'sd1,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_OPEN_ANN,   16'sd0,     1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      send_request(CMD_OPEN_DONE,  16'sd1023,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_READ,       16'sd1023,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_WRITE,      16'sd1023,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_READ,       16'sd1023,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_CLOSE_DONE, 16'sd1023,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_CLOSE_DONE, 16'sd1023,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_READ,       16'sd1023,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_OPEN_ANN,   16'sd0,     1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      send_request(CMD_OPEN_ANN,   16'sd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_OPEN_DONE,  -16'sd1,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_OPEN_DONE,  16'sd32767, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_OPEN_ANN,   16'sd0,     1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      send_request(CMD_OPEN_DONE,  16'sd32767, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_READ,       16'sd1024,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_WRITE,      16'sh8000,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_INHERIT,    16'sd1024,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_request(CMD_CLOSE_DONE, -16'sd1,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(3'd6,           16'sd2,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_request(3'd7,           16'sd3,     1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      drain_responses();

      // Random: mostly well-formed open sessions, the rest loose requests
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (coin(65))
            run_open_session();
         else
            send_request(3'($urandom_range(0, 7)), pick_fd(), coin(50), coin(50),
                         coin(50), coin(50), coin(50));
         if ((random_sent / 300) != ((sent_total - 27) / 300))
            drain_responses();
         random_sent = sent_total - 27;
      end

      // Wait for the tail and give the block time to show anything stray
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests: inherit %0d, open announce %0d, open done %0d,",
               sent_total, cmd_seen[0], cmd_seen[1], cmd_seen[2]);
      $display("  close done %0d, read %0d, write %0d, undefined %0d; %0d responses checked",
               cmd_seen[3], cmd_seen[4], cmd_seen[5], cmd_seen[6] + cmd_seen[7],
               checked_count);
      if (mismatch_count == 0 && owed_count == 0)
         $display("descriptor_access_policy_table_test: done, clean");
      else
         $display("descriptor_access_policy_table_test: done, errors");
      $finish;
   end

   // Give up if the run stalls
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("descriptor_access_policy_table_test: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/dapt_pkg.sv
hdl/descriptor_access_policy_table.sv
tb/sv/descriptor_access_policy_table_checker.sv
tb/sv/descriptor_access_policy_table_test.sv
